// ===== src/spq_pkg.sv =====
// Shared types and constants for the sorted priority queue.
// Depends on nothing; every other file in src imports it.
package spq_pkg;

   // Fixed widths of the stream fields
   localparam int KEY_BITS   = 16;
   localparam int COUNT_BITS = 5;

   // Operation codes carried in req_tuser
   typedef enum logic [1:0] {
      OP_PUSH  = 2'd0,
      OP_POLL  = 2'd1,
      OP_CLEAR = 2'd2,
      OP_NOP   = 2'd3
   } op_type;

   // Result status codes
   typedef enum logic [1:0] {
      ST_OK    = 2'd0,
      ST_EMPTY = 2'd1,
      ST_FULL  = 2'd2,
      ST_RSVD  = 2'd3
   } status_type;

   // Shift commands broadcast to every cell, already qualified by fill state
   typedef struct packed {
      logic push;
      logic poll;
   } ctl_type;

   // One result beat, packed in tdata order from the top bit down
   typedef struct packed {
      status_type             status;
      logic [COUNT_BITS-1:0]  count;
      logic                   empty_res;
      logic [KEY_BITS-1:0]    top_key;
   } rsp_type;

endpackage

// ===== src/sorted_priority_queue_top.sv =====
// Top level of the max-first sorted priority queue: a chain of key cells,
// fill counter and result buffer. Depends on spq_pkg, spq_cell, spq_rsp_buf.
//
//   Channel | Direction | Fields (low bit up)
//   req_    | in        | tuser: op[1:0]; tdata: key[15:0]
//   rsp_    | out       | tdata: top_key[15:0] empty_res[16] count[21:17]
//           |           |        status[23:22]
//
// One push, poll or clear is taken every cycle while the result buffer has room; each cell compares and
// shifts in parallel, so the cell chain sets the rate at one item a cycle.
// The result is registered in the result buffer before it appears on rsp.
// Synchronous reset empties the queue and the result buffer; keys need none.
// req_tready drops only while two results wait in the buffer.
module sorted_priority_queue_top #(
   parameter int DEPTH     = 16,
   parameter int KEY_WIDTH = 16
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [1:0]  req_tuser,   // op[1:0]
   input  logic [15:0] req_tdata,   // key[15:0]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [23:0] rsp_tdata    // top_key, empty_res, count, status
);
   import spq_pkg::*;

   localparam int CNT_W = $clog2(DEPTH + 1);

   logic                  req_acc;
   op_type                op;
   logic [KEY_WIDTH+KEY_BITS-1:0] key_wide;
   logic [KEY_WIDTH-1:0]  key_ext;
   logic [CNT_W-1:0]      cnt_ff, cnt_in;
   logic                  full, empty;
   status_type            status;
   ctl_type               ctl;
   logic                  gt       [DEPTH];
   logic [KEY_WIDTH-1:0]  key_q    [DEPTH];
   logic [KEY_WIDTH-1:0]  key_next [DEPTH];
   logic [KEY_WIDTH+KEY_BITS-1:0] top_wide;
   logic [CNT_W+COUNT_BITS-1:0]   cnt_wide;
   rsp_type               rsp_beat;
   rsp_type               rsp_out;

   assign req_acc = req_tvalid && req_tready;
   assign op      = op_type'(req_tuser);

   // Fit the incoming key to the stored key width
   assign key_wide = {{KEY_WIDTH{1'b0}}, req_tdata};
   assign key_ext  = key_wide[KEY_WIDTH-1:0];

   assign full  = (cnt_ff == CNT_W'(DEPTH));
   assign empty = (cnt_ff == '0);

   // Next fill count and status of the operation
   always_comb begin
      cnt_in = cnt_ff;
      status = ST_OK;
      ctl    = '0;
      if (req_acc) begin
         unique case (op)
            OP_PUSH: begin
               if (full) begin
                  status = ST_FULL;
               end else begin
                  ctl.push = 1'b1;
                  cnt_in   = cnt_ff + 1'b1;
               end
            end
            OP_POLL: begin
               if (empty) begin
                  status = ST_EMPTY;
               end else begin
                  ctl.poll = 1'b1;
                  cnt_in   = cnt_ff - 1'b1;
               end
            end
            OP_CLEAR: begin
               cnt_in = '0;
            end
            OP_NOP: begin
               cnt_in = cnt_ff;
            end
            default: begin
               cnt_in = cnt_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0;
      end else begin
         cnt_ff <= cnt_in;
      end
   end

   // Build the cell chain, front of the queue in cell 0
   for (genvar i = 0; i < DEPTH; i++) begin : g_cell
      logic                 occ;
      logic                 lgt;
      logic [KEY_WIDTH-1:0] lkey;
      logic [KEY_WIDTH-1:0] rkey;

      assign occ = (CNT_W'(i) < cnt_ff);
      if (i == 0) begin : g_first
         assign lgt  = 1'b0;
         assign lkey = key_ext;
      end else begin : g_mid
         assign lgt  = gt[i-1];
         assign lkey = key_q[i-1];
      end
      if (i == DEPTH - 1) begin : g_last
         assign rkey = key_q[i];
      end else begin : g_inner
         assign rkey = key_q[i+1];
      end

      spq_cell #(
         .KEY_WIDTH (KEY_WIDTH)
      ) u_cell (
         .clock     (clock),
         .ctl       (ctl),
         .occupied  (occ),
         .new_key   (key_ext),
         .left_gt   (lgt),
         .left_key  (lkey),
         .right_key (rkey),
         .gt        (gt[i]),
         .key_q     (key_q[i]),
         .key_next  (key_next[i])
      );
   end

   // Form the result from the state after the operation
   assign top_wide = {{KEY_BITS{1'b0}}, key_next[0]};
   assign cnt_wide = {{COUNT_BITS{1'b0}}, cnt_in};

   always_comb begin
      rsp_beat.top_key   = (cnt_in == '0) ? '0 : top_wide[KEY_BITS-1:0];
      rsp_beat.empty_res = (cnt_in == '0);
      rsp_beat.count     = cnt_wide[COUNT_BITS-1:0];
      rsp_beat.status    = status;
   end

   spq_rsp_buf u_rsp_buf (
      .clock    (clock),
      .reset    (reset),
      .wr_en    (req_acc),
      .wr_data  (rsp_beat),
      .has_room (req_tready),
      .rd_valid (rsp_tvalid),
      .rd_ready (rsp_tready),
      .rd_data  (rsp_out)
   );

   assign rsp_tdata = rsp_out;

   // Fill count stays within the chain length
   a_cnt_range: assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= CNT_W'(DEPTH))
      else $error("fill count beyond depth");

   // A clear empties the queue
   a_clear: assert property (@(posedge clock) disable iff (reset)
      (req_acc && op == OP_CLEAR) |=> (cnt_ff == '0))
      else $error("clear left entries");

   // Front two entries stay in descending order
   a_sorted: assert property (@(posedge clock) disable iff (reset)
      (cnt_ff >= CNT_W'(2)) |-> ($signed(key_q[0]) >= $signed(key_q[1])))
      else $error("front entries out of order");

   // A push into a full queue leaves the count alone
   a_full_push: assert property (@(posedge clock) disable iff (reset)
      (req_acc && op == OP_PUSH && full) |=> (cnt_ff == CNT_W'(DEPTH)))
      else $error("push into full queue changed count");

endmodule

// ===== src/spq_cell.sv =====
// One slot of the sorted key chain: holds a key, compares it against a
// pushed key and shifts toward either neighbor. Depends on spq_pkg.
module spq_cell #(
   parameter int KEY_WIDTH = 16
) (
   input  logic                  clock,
   input  spq_pkg::ctl_type      ctl,
   input  logic                  occupied,
   input  logic [KEY_WIDTH-1:0]  new_key,
   input  logic                  left_gt,
   input  logic [KEY_WIDTH-1:0]  left_key,
   input  logic [KEY_WIDTH-1:0]  right_key,
   output logic                  gt,
   output logic [KEY_WIDTH-1:0]  key_q,
   output logic [KEY_WIDTH-1:0]  key_next
);
   import spq_pkg::*;

   logic [KEY_WIDTH-1:0] key_ff;
   logic [KEY_WIDTH-1:0] key_in;

   // At or past the insert point: slot is free or holds a strictly smaller key
   assign gt = ctl.push && (!occupied || ($signed(new_key) > $signed(key_ff)));

   // Shift down on push past the insert point, shift up on poll
   always_comb begin
      key_in = key_ff;
      priority if (gt) begin
         key_in = left_gt ? left_key : new_key;
      end else if (ctl.poll) begin
         key_in = right_key;
      end
   end

   always_ff @(posedge clock) begin
      key_ff <= key_in;
   end

   assign key_q    = key_ff;
   assign key_next = key_in;

endmodule

// ===== src/spq_rsp_buf.sv =====
// Two-entry result buffer between the queue update and the rsp stream.
// Depends on spq_pkg for the result beat layout.
module spq_rsp_buf (
   input  logic              clock,
   input  logic              reset,
   input  logic              wr_en,
   input  spq_pkg::rsp_type  wr_data,
   output logic              has_room,
   output logic              rd_valid,
   input  logic              rd_ready,
   output spq_pkg::rsp_type  rd_data
);
   import spq_pkg::*;

   rsp_type    slot_ff [2];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] occ_ff, occ_in;
   logic       rd_en;

   assign rd_en    = rd_valid && rd_ready;
   assign has_room = (occ_ff != 2'd2);
   assign rd_valid = (occ_ff != 2'd0);
   assign rd_data  = slot_ff[rd_ptr_ff];

   // Advance pointers and occupancy
   always_comb begin
      wr_ptr_in = wr_en ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = rd_en ? ~rd_ptr_ff : rd_ptr_ff;
      occ_in    = occ_ff + {1'b0, wr_en} - {1'b0, rd_en};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         occ_ff    <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         occ_ff    <= occ_in;
      end
   end

   // Store the beat
   always_ff @(posedge clock) begin
      if (wr_en) begin
         slot_ff[wr_ptr_ff] <= wr_data;
      end
   end

endmodule
